// File: design/assert_macros.svh
// Assertion macros shared by the RTL of the key matrix scanner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Antecedent holds in this cycle, so the consequent must hold in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
// Antecedent holds in this cycle, so the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/kmsd_pkg.sv
// Package with widths, constants and helpers of the key matrix scanner.
package kmsd_pkg;

  localparam int unsigned ROWS_DEF      = 8;
  localparam int unsigned COLS_DEF      = 8;
  localparam int unsigned ROW_IDX_W     = 3;
  localparam int unsigned COL_W         = 8;
  localparam int unsigned COL_IDX_W     = 3;
  localparam int unsigned SCANS_W       = 8;
  localparam int unsigned KEY_CNT_W     = 7;
  localparam int unsigned POP_W         = 4;
  localparam int unsigned S_TDATA_W     = 16;
  localparam int unsigned M_TDATA_W     = 24;

  localparam logic [SCANS_W-1:0]   DEBOUNCE_RESET = 8'd5;
  localparam logic [KEY_CNT_W-1:0] KEY_CNT_MAX    = 7'd127;

  // Number of set bits in one row.
  function automatic logic [POP_W-1:0] pop_row(input logic [COL_W-1:0] v);
    logic [POP_W-1:0] n;
    n = '0;
    for (int b = 0; b < COL_W; b++) begin
      n = n + POP_W'(v[b]);
    end
    return n;
  endfunction

endpackage

// File: design/key_matrix_scan_debounce_top.sv
// Key matrix row scanner with one shared debounce counter and a skid-buffered result port.
// A result word reaches the master side through the output register, or via the skid register.
// One row word per cycle while the skid slot is empty; the compare, settle count and commit
//   are all combinational between the input handshake and the result register.
// Two result slots (output register and skid register) let a word be taken while a result waits.
// Reset (rst_ni low, asynchronous) clears samples and committed matrix, sets the settle count
//   and the debounce register to 5 and empties both result slots.
`include "assert_macros.svh"

module key_matrix_scan_debounce_top
  import kmsd_pkg::*;
#(
  parameter int unsigned ROWS = ROWS_DEF,
  parameter int unsigned COLS = COLS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Configuration: debounce_scans.
  input  logic                 cfg_we_i,
  input  logic [SCANS_W-1:0]   cfg_wdata_i,
  // Row sample words.
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // From bit 0: row_index[2:0], raw_cols[10:3], query_col[13:11], zero fill [15:14].
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // scan_end: last row of a full scan.
  input  logic                 s_axis_tlast,
  // Result words.
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // From bit 0: stable_row[7:0], key_on[8], settled[9], bounce[10], key_count[17:11],
  // zero fill [23:18].
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  // Width of a counter that can hold the key total of the whole sampled matrix.
  localparam int unsigned CntW = $clog2(ROWS * COLS + 1);

  // Columns at or beyond COLS never report a key.
  localparam logic [COL_W-1:0] ColMask = COL_W'((33'(1) << ((COLS < COL_W) ? COLS : COL_W)) - 1);

  // Result fields as carried in the output and skid registers.
  typedef struct packed {
    logic [KEY_CNT_W-1:0] key_count;
    logic                 bounce;
    logic                 settled;
    logic                 key_on;
    logic [COL_W-1:0]     stable_row;
  } result_t;

  // ---------------------------------------------------------------------------------------------
  // Input unpacking
  // ---------------------------------------------------------------------------------------------
  logic [ROW_IDX_W-1:0] row_index;
  logic [COL_W-1:0]     raw_cols;
  logic [COL_IDX_W-1:0] query_col;
  logic                 scan_end;

  assign row_index = s_axis_tdata[ROW_IDX_W-1:0];
  assign raw_cols  = s_axis_tdata[ROW_IDX_W +: COL_W];
  assign query_col = s_axis_tdata[ROW_IDX_W + COL_W +: COL_IDX_W];
  assign scan_end  = s_axis_tlast;

  // ---------------------------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------------------------
  logic [SCANS_W-1:0] debounce_q;
  logic [SCANS_W-1:0] settle_q, settle_d;
  logic [COL_W-1:0]   sampled_q   [ROWS];
  logic [COL_W-1:0]   sampled_d   [ROWS];
  logic [COL_W-1:0]   committed_q [ROWS];
  // Running key totals of the sampled and the committed matrix, kept up to date one row at a
  // time so that no wide popcount over the matrix is needed.
  logic [CntW-1:0]    samp_cnt_q, samp_cnt_d;
  logic [CntW-1:0]    comm_cnt_q;

  logic in_fire, out_fire;
  logic skid_valid_q, out_valid_q;
  result_t out_q, skid_q, res;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;

  // ---------------------------------------------------------------------------------------------
  // Per-word compare, settle count and commit decision
  // ---------------------------------------------------------------------------------------------
  logic               row_ok;
  logic [COL_W-1:0]   sample;
  logic [COL_W-1:0]   old_row;
  logic [COL_W-1:0]   comm_row;
  logic [COL_W-1:0]   new_row;
  logic               changed;
  logic [SCANS_W-1:0] reload;
  logic [SCANS_W-1:0] cnt_a;
  logic               dec;
  logic               commit;
  logic [COL_W-1:0]   stable;
  logic [CntW-1:0]    cnt_sel;

  assign row_ok = int'(row_index) < int'(ROWS);
  assign sample = ~raw_cols & ColMask;

  always_comb begin
    old_row  = '0;
    comm_row = '0;
    for (int r = 0; r < ROWS; r++) begin
      if (int'(row_index) == r) begin
        old_row  = sampled_q[r];
        comm_row = committed_q[r];
      end
    end
  end

  assign changed = row_ok && (old_row != sample);
  // A zero reload value still commits at the next scan end.
  assign reload  = (debounce_q == '0) ? SCANS_W'(1) : debounce_q;
  // Reload first, then the scan-end countdown in the same word.
  assign cnt_a   = changed ? reload : settle_q;
  assign dec     = scan_end && (cnt_a != '0);
  assign settle_d = dec ? (cnt_a - SCANS_W'(1)) : cnt_a;
  assign commit  = dec && (cnt_a == SCANS_W'(1));

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      sampled_d[r] = (changed && (int'(row_index) == r)) ? sample : sampled_q[r];
    end
  end

  assign samp_cnt_d = changed
                    ? (samp_cnt_q - CntW'(pop_row(old_row)) + CntW'(pop_row(sample)))
                    : samp_cnt_q;

  // The committed row after this word: a commit makes it the freshly stored sample.
  assign new_row = commit ? (changed ? sample : old_row) : comm_row;
  assign stable  = row_ok ? new_row : '0;
  assign cnt_sel = commit ? samp_cnt_d : comm_cnt_q;

  always_comb begin
    res.stable_row = stable;
    res.key_on     = stable[query_col];
    res.settled    = (settle_d == '0);
    res.bounce     = changed && (settle_q != '0);
    res.key_count  = (32'(cnt_sel) > 32'(KEY_CNT_MAX)) ? KEY_CNT_MAX : KEY_CNT_W'(cnt_sel);
  end

  // ---------------------------------------------------------------------------------------------
  // State registers
  // ---------------------------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q <= DEBOUNCE_RESET;
    end else if (cfg_we_i) begin
      debounce_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q   <= DEBOUNCE_RESET;
      samp_cnt_q <= '0;
      comm_cnt_q <= '0;
      for (int r = 0; r < ROWS; r++) begin
        sampled_q[r]   <= '0;
        committed_q[r] <= '0;
      end
    end else if (in_fire) begin
      settle_q   <= settle_d;
      samp_cnt_q <= samp_cnt_d;
      for (int r = 0; r < ROWS; r++) begin
        sampled_q[r] <= sampled_d[r];
      end
      if (commit) begin
        comm_cnt_q <= samp_cnt_d;
        for (int r = 0; r < ROWS; r++) begin
          committed_q[r] <= sampled_d[r];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Result register with skid slot. The input side is ready whenever the skid slot is empty, so
  // a new word is still taken while one finished result waits on the master side.
  // ---------------------------------------------------------------------------------------------
  assign s_axis_tready = !skid_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_fire) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_fire) begin
        out_q <= skid_q;
      end
    end else if (in_fire) begin
      if (out_valid_q && !out_fire) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_q);

  // ---------------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------------
  // The skid slot only fills behind a waiting result.
  `ASSERT_IMPLY(a_skid_behind_out, clk_i, rst_ni, skid_valid_q, out_valid_q)
  // A commit leaves the settle counter at zero.
  `ASSERT_NEXT(a_commit_settles, clk_i, rst_ni, in_fire && commit, settle_q == '0)
  // A settled matrix with an unchanged sample stays settled.
  `ASSERT_NEXT(a_settled_holds, clk_i, rst_ni, in_fire && !changed && (settle_q == '0),
               settle_q == '0)
  // While settled, the committed matrix equals the samples, so their totals agree.
  `ASSERT_IMPLY(a_counts_agree, clk_i, rst_ni, settle_q == '0, comm_cnt_q == samp_cnt_q)

endmodule
